/* design/elevator_request_controller_defines.svh */
// Assertion macros shared by the elevator request controller modules
`ifndef ELEVATOR_REQUEST_CONTROLLER_DEFINES_SVH
`define ELEVATOR_REQUEST_CONTROLLER_DEFINES_SVH

// check cons in the same cycle as ante
`define ERC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// check cons in the cycle after ante
`define ERC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/erc_pkg.sv */
// Types, constants and codes of the elevator request controller
package erc_pkg;

  localparam int FLOOR_COUNT = 10;
  localparam int FLOOR_W     = $clog2(FLOOR_COUNT + 1);
  localparam int CNT_W       = FLOOR_W;

  localparam int TOUCH_W     = 10;
  localparam int RAW_W       = 1024;
  localparam int RAW_H       = 600;
  localparam int SCREEN_W    = 800;
  localparam int SCREEN_H    = 480;
  localparam int COL_LEFT_X  = 600;
  localparam int COL_RIGHT_X = 700;
  localparam int ROW_H       = 96;

  localparam int ROW_COUNT   = SCREEN_H / ROW_H;
  localparam int ROW_W       = $clog2(ROW_COUNT);
  localparam int ROW_RAW_H   = ROW_H * RAW_H / SCREEN_H;
  localparam int RAW_X_SHIFT = $clog2(RAW_W);
  localparam int SX_W        = $clog2(SCREEN_W);
  localparam int SX_PROD_W   = TOUCH_W + SX_W;
  localparam int NUM_W       = $clog2(2 * ROW_COUNT + 1);
  localparam int ROWY_W      = 9;
  localparam int EVENT_W     = 3;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic OP_TOUCH = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  localparam logic [EVENT_W-1:0] EV_OUTSIDE    = 3'd0;
  localparam logic [EVENT_W-1:0] EV_BLINK      = 3'd1;
  localparam logic [EVENT_W-1:0] EV_REGISTERED = 3'd2;
  localparam logic [EVENT_W-1:0] EV_CANCELLED  = 3'd3;
  localparam logic [EVENT_W-1:0] EV_IDLE       = 3'd4;
  localparam logic [EVENT_W-1:0] EV_MOVING     = 3'd5;

  typedef struct packed {
    logic               op;
    logic [FLOOR_W-1:0] floor;
    logic               column;
    logic [ROWY_W-1:0]  row_y;
  } item_t;

  typedef struct packed {
    logic [EVENT_W-1:0]     event_res;
    logic [FLOOR_W-1:0]     button_floor;
    logic                   button_column;
    logic [ROWY_W-1:0]      button_row_y;
    logic                   door_open;
    logic [FLOOR_W-1:0]     car_floor;
    logic                   going_down;
    logic [FLOOR_COUNT-1:0] request_mask;
    logic [CNT_W-1:0]       above_count;
    logic [CNT_W-1:0]       below_count;
  } result_t;

endpackage

/* design/erc_in_if.sv */
// Input channel: touch or tick items
interface erc_in_if import erc_pkg::*;;
  logic               valid;
  logic               ready;
  logic               op;
  logic [TOUCH_W-1:0] touch_x;
  logic [TOUCH_W-1:0] touch_y;

  modport source(output valid, op, touch_x, touch_y, input ready);
  modport sink(input valid, op, touch_x, touch_y, output ready);
endinterface

/* design/erc_out_if.sv */
// Output channel: one result per item
interface erc_out_if import erc_pkg::*;;
  logic                   valid;
  logic                   ready;
  logic [EVENT_W-1:0]     event_res;
  logic [FLOOR_W-1:0]     button_floor;
  logic                   button_column;
  logic [ROWY_W-1:0]      button_row_y;
  logic                   door_open;
  logic [FLOOR_W-1:0]     car_floor;
  logic                   going_down;
  logic [FLOOR_COUNT-1:0] request_mask;
  logic [CNT_W-1:0]       above_count;
  logic [CNT_W-1:0]       below_count;

  modport source(output valid, event_res, button_floor, button_column, button_row_y,
                 door_open, car_floor, going_down, request_mask, above_count,
                 below_count, input ready);
  modport sink(input valid, event_res, button_floor, button_column, button_row_y,
               door_open, car_floor, going_down, request_mask, above_count,
               below_count, output ready);
endinterface

/* design/erc_front.sv */
// Front end: accept items, scale and decode touches to a button
module erc_front import erc_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  erc_in_if.sink in_ch,
  output logic  item_valid,
  input  logic  item_ready,
  output item_t item
);

  logic [SX_PROD_W-1:0] x_prod;
  logic [SX_W-1:0]      sx;
  logic [ROW_W-1:0]     row;
  logic [NUM_W-1:0]     num;
  logic                 in_grid;
  logic                 hit;
  item_t                item_next;
  logic                 valid;

  always_comb begin
    x_prod = SX_PROD_W'(in_ch.touch_x) * SX_PROD_W'(SCREEN_W);
    sx     = SX_W'(x_prod >> RAW_X_SHIFT);
    row    = '0;
    for (int r = 1; r < ROW_COUNT; r++) begin
      if (in_ch.touch_y >= TOUCH_W'(r * ROW_RAW_H)) begin
        row = ROW_W'(r);
      end
    end
    in_grid = (sx >= SX_W'(COL_LEFT_X)) && (sx < SX_W'(SCREEN_W)) &&
              (in_ch.touch_y < TOUCH_W'(RAW_H));
    num = NUM_W'({row, 1'b0}) + ((sx < SX_W'(COL_RIGHT_X)) ? NUM_W'(1) : NUM_W'(2));
    hit = (in_ch.op == OP_TOUCH) && in_grid && (num <= NUM_W'(FLOOR_COUNT));

    item_next    = '0;
    item_next.op = in_ch.op;
    if (hit) begin
      item_next.floor  = FLOOR_W'(num);
      item_next.column = num[0];
      item_next.row_y  = ROWY_W'(row) * ROWY_W'(ROW_H);
    end
  end

  assign in_ch.ready = !valid || item_ready;
  assign item_valid  = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ch.ready) begin
      valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      item <= item_next;
    end
  end

endmodule

/* design/erc_queue.sv */
// Short item queue between front end and back end
`include "elevator_request_controller_defines.svh"
module erc_queue import erc_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  output logic  out_valid,
  input  logic  out_ready,
  output item_t out_item
);

  item_t             entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push;
  logic              pop;

  assign in_ready  = (count != QCNT_W'(QUEUE_DEPTH));
  assign out_valid = (count != '0);
  assign out_item  = entries[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= in_item;
    end
  end

  `ERC_ASSERT_NOW(a_no_overflow, 1'b1, count <= QCNT_W'(QUEUE_DEPTH), "queue fill above depth")
  `ERC_ASSERT_NEXT(a_fill_up, push && !pop, count == $past(count) + QCNT_W'(1), "fill lost a push")
  `ERC_ASSERT_NEXT(a_fill_down, pop && !push, count + QCNT_W'(1) == $past(count), "fill lost a pop")

endmodule

/* design/erc_back.sv */
// Back end: toggle requests, step the car in LOOK order, register the result
`include "elevator_request_controller_defines.svh"
module erc_back import erc_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  item_valid,
  output logic  item_ready,
  input  item_t item,
  erc_out_if.source out_ch
);

  logic [FLOOR_COUNT-1:0] pending;
  logic [FLOOR_COUNT-1:0] pending_next;
  logic [FLOOR_W-1:0]     cur;
  logic [FLOOR_W-1:0]     cur_next;
  logic                   down;
  logic                   down_next;
  logic                   res_valid;
  result_t                res;
  result_t                res_next;
  logic                   load;
  logic                   moved;
  logic                   up_any;
  logic                   dn_any;
  logic [FLOOR_COUNT-1:0] p_tick;
  logic [FLOOR_COUNT-1:0] here_vec;
  logic [FLOOR_COUNT-1:0] above_vec;
  logic [FLOOR_COUNT-1:0] below_vec;
  logic [FLOOR_COUNT-1:0] sel_vec;
  logic [FLOOR_COUNT-1:0] atleast_vec;
  logic [FLOOR_COUNT-1:0] atmost_vec;
  logic [CNT_W-1:0]       above_cnt;
  logic [CNT_W-1:0]       below_cnt;

  assign item_ready = !res_valid || out_ch.ready;
  assign load       = item_valid && item_ready;

  always_comb begin
    for (int k = 0; k < FLOOR_COUNT; k++) begin
      here_vec[k]  = (cur == FLOOR_W'(k + 1));
      above_vec[k] = (cur < FLOOR_W'(k + 1));
      below_vec[k] = (cur > FLOOR_W'(k + 1));
      sel_vec[k]   = (item.floor == FLOOR_W'(k + 1));
    end
  end

  always_comb begin
    pending_next = pending;
    cur_next     = cur;
    down_next    = down;
    res_next     = '0;
    moved        = 1'b0;
    p_tick       = pending & ~here_vec;
    up_any       = |(p_tick & above_vec);
    dn_any       = |(p_tick & below_vec);

    if (item.op == OP_TOUCH) begin
      res_next.button_floor  = item.floor;
      res_next.button_column = item.column;
      res_next.button_row_y  = item.row_y;
      priority if (item.floor == '0) begin
        res_next.event_res = EV_OUTSIDE;
      end else if (|(pending & sel_vec)) begin
        pending_next       = pending & ~sel_vec;
        res_next.event_res = EV_CANCELLED;
      end else if (item.floor == cur) begin
        res_next.event_res = EV_BLINK;
      end else begin
        pending_next       = pending | sel_vec;
        res_next.event_res = EV_REGISTERED;
      end
    end else begin
      res_next.door_open = |(pending & here_vec);
      pending_next       = p_tick;
      if (!down) begin
        if (up_any) begin
          cur_next = cur + FLOOR_W'(1);
          moved    = 1'b1;
        end else if (dn_any) begin
          down_next = 1'b1;
          cur_next  = cur - FLOOR_W'(1);
          moved     = 1'b1;
        end
      end else begin
        if (dn_any) begin
          cur_next = cur - FLOOR_W'(1);
          moved    = 1'b1;
        end else if (up_any) begin
          down_next = 1'b0;
          cur_next  = cur + FLOOR_W'(1);
          moved     = 1'b1;
        end
      end
      res_next.event_res = moved ? EV_MOVING : EV_IDLE;
    end

    above_cnt = '0;
    below_cnt = '0;
    for (int k = 0; k < FLOOR_COUNT; k++) begin
      atleast_vec[k] = (cur_next <= FLOOR_W'(k + 1));
      atmost_vec[k]  = (cur_next >= FLOOR_W'(k + 1));
      above_cnt = above_cnt + CNT_W'(pending_next[k] & atleast_vec[k]);
      below_cnt = below_cnt + CNT_W'(pending_next[k] & atmost_vec[k]);
    end

    res_next.car_floor    = cur_next;
    res_next.going_down   = down_next;
    res_next.request_mask = pending_next;
    res_next.above_count  = above_cnt;
    res_next.below_count  = below_cnt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending   <= '0;
      cur       <= FLOOR_W'(1);
      down      <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (load) begin
        pending <= pending_next;
        cur     <= cur_next;
        down    <= down_next;
      end
      if (item_ready) begin
        res_valid <= item_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res <= res_next;
    end
  end

  assign out_ch.valid         = res_valid;
  assign out_ch.event_res     = res.event_res;
  assign out_ch.button_floor  = res.button_floor;
  assign out_ch.button_column = res.button_column;
  assign out_ch.button_row_y  = res.button_row_y;
  assign out_ch.door_open     = res.door_open;
  assign out_ch.car_floor     = res.car_floor;
  assign out_ch.going_down    = res.going_down;
  assign out_ch.request_mask  = res.request_mask;
  assign out_ch.above_count   = res.above_count;
  assign out_ch.below_count   = res.below_count;

  `ERC_ASSERT_NOW(a_floor_range, 1'b1, (cur != '0) && (cur <= FLOOR_W'(FLOOR_COUNT)), "car floor out of range")
  `ERC_ASSERT_NEXT(a_step_one, load && moved, (cur == $past(cur) + FLOOR_W'(1)) || (cur + FLOOR_W'(1) == $past(cur)), "car moved more than one floor")
  `ERC_ASSERT_NEXT(a_tick_clears_only, load && (item.op == OP_TICK), (pending & ~$past(pending)) == '0, "tick set a request bit")

endmodule

/* design/elevator_request_controller.sv */
// Elevator request controller top level
//
// Input channel in_ch carries one item per transfer: op 0 is a panel touch
// (touch_x, touch_y in raw 1024x600 panel units), op 1 is one movement tick.
// Output channel out_ch returns exactly one result per item, in order: the
// event code, the decoded button, door, car floor, direction, request bits
// and the at-or-above / at-or-below request counts.
// An item passes the front register (loaded on the input transfer), then a
// queue entry, then the result register, where its result is offered.
// Throughput: one item per cycle while out_ch does not stall; the back end
// updates the request/car state as it takes each item.
// The front end classifies touches and a two-entry queue decouples it from
// the back end, so each side stalls on its own.
// Reset (rst, synchronous): no requests, car at floor 1, heading up, all
// channels empty. When out_ch is stalled the result register holds, the
// queue fills, and in_ch.ready drops after the front register and queue
// are full.
module elevator_request_controller import erc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  erc_in_if.sink    in_ch,
  erc_out_if.source out_ch
);

  logic  f_valid;
  logic  f_ready;
  item_t f_item;
  logic  q_valid;
  logic  q_ready;
  item_t q_item;

  erc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_ch      (in_ch),
    .item_valid (f_valid),
    .item_ready (f_ready),
    .item       (f_item)
  );

  erc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_item   (f_item),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_item  (q_item)
  );

  erc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (q_valid),
    .item_ready (q_ready),
    .item       (q_item),
    .out_ch     (out_ch)
  );

endmodule
